FILE: rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared widths, register map and reset values of the retry backoff delay unit.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int ATTEMPT_BITS  = 16;
  localparam int RANDOM_BITS   = 32;
  localparam int PCT_BITS      = 7;
  localparam int LIMIT_BITS    = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  // register indexes, address bits [3:2]
  localparam logic [1:0] REG_START_WAIT     = 2'd0;
  localparam logic [1:0] REG_WAIT_CAP       = 2'd1;
  localparam logic [1:0] REG_JITTER_PERCENT = 2'd2;
  localparam logic [1:0] REG_ATTEMPT_LIMIT  = 2'd3;

  localparam int START_WAIT_RESET = 1000;
  localparam int WAIT_CAP_RESET   = 60000;

  // percentage divisor and its remainder width
  localparam int PCT_DIVISOR  = 100;
  localparam int PCT_REM_BITS = 7;

  // delay / 100 as (delay * ceil(2^38 / 100)) >> 38, exact for delays below 2^32
  localparam int                    RECIP_BITS      = 32;
  localparam logic [RECIP_BITS-1:0] PCT_RECIP       = 32'd2748779070;
  localparam int                    PCT_RECIP_SHIFT = 38;

  // (remainder * percent) / 100 as (x * ceil(2^20 / 100)) >> 20, exact below 43690
  localparam int                   FRAC_BITS        = PCT_REM_BITS + PCT_BITS;
  localparam logic [FRAC_BITS-1:0] FRAC_RECIP       = 14'd10486;
  localparam int                   FRAC_RECIP_SHIFT = 20;

endpackage

FILE: rtl/rbd_req_if.sv
// ----------------------------------------------------------------------------
// rbd_req_if
// Request channel: attempt numbers and random word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbd_req_if;
  logic                               valid;
  logic                               ready;
  logic [rbd_pkg::ATTEMPT_BITS-1:0]   attempt_number;
  logic [rbd_pkg::ATTEMPT_BITS-1:0]   next_attempt_number;
  logic [rbd_pkg::RANDOM_BITS-1:0]    random_word;

  modport source (output valid, attempt_number, next_attempt_number, random_word,
                  input ready);
  modport sink (input valid, attempt_number, next_attempt_number, random_word,
                output ready);
endinterface

FILE: rtl/rbd_rsp_if.sv
// ----------------------------------------------------------------------------
// rbd_rsp_if
// Response channel: suggested wait and attempt permission, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbd_rsp_if #(
  parameter int DELAY_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [DELAY_BITS-1:0] wait_ms;
  logic                  attempt_allowed;

  modport source (output valid, wait_ms, attempt_allowed, input ready);
  modport sink (input valid, wait_ms, attempt_allowed, output ready);
endinterface

FILE: rtl/retry_backoff_delay_unit.sv
// ----------------------------------------------------------------------------
// retry_backoff_delay_unit
// Exponential retry backoff with optional percentage jitter and attempt limit.
// ----------------------------------------------------------------------------
// One request gives one response. The unit is a single pipeline of 39
// register stages, and a new request is taken every cycle unless the
// first stage holds a stalled item. Most of the pipeline length is
// the random word modulo (2*jitter+1), a restoring modulo with one stage per
// random bit (32 stages); the backoff takes one stage, the jitter percentage
// four (the division by 100 is a reciprocal multiplication) and the offset
// and clamp two more. Each stage holds its item while the stage after it
// cannot take it, so bubbles close up and a stalled response does not
// block new requests until the pipe is full. Registers are written
// through the APB port and must only change while no request is in flight.
// ----------------------------------------------------------------------------
module retry_backoff_delay_unit #(
  parameter int DELAY_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rbd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rbd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  rbd_req_if.sink                           req,
  rbd_rsp_if.source                         rsp
);

  localparam int DB        = DELAY_BITS;
  localparam int RB        = rbd_pkg::RANDOM_BITS;
  localparam int PW        = DB + rbd_pkg::PCT_BITS;   // product width
  localparam int SW        = $clog2(DB);
  localparam int QW        = DB + rbd_pkg::RECIP_BITS;
  localparam int FW        = 2 * rbd_pkg::FRAC_BITS;
  localparam int PREP      = 5;
  localparam int MOD_FIRST = PREP + 1;
  localparam int LAST      = MOD_FIRST + RB;
  localparam int NS        = LAST + 1;

  typedef struct packed {
    logic                                allowed;
    logic [DB-1:0]                       delay;
    logic [RB-1:0]                       rnd;
    logic [DB-1:0]                       quo;
    logic [rbd_pkg::PCT_REM_BITS-1:0]    prem;
    logic [rbd_pkg::FRAC_BITS-1:0]       tprod;
    logic [PW-1:0]                       num;
    logic [DB-1:0]                       lo;
    logic [DB:0]                         range;
    logic [DB:0]                         mrem;
    logic                                jz;
  } stage_t;

  // configuration registers
  logic [DB-1:0]                    start_wait;
  logic [DB-1:0]                    wait_cap;
  logic [rbd_pkg::PCT_BITS-1:0]     jitter_percent;
  logic [rbd_pkg::LIMIT_BITS-1:0]   attempt_limit;
  logic                             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_wait     <= DB'(rbd_pkg::START_WAIT_RESET);
      wait_cap       <= DB'(rbd_pkg::WAIT_CAP_RESET);
      jitter_percent <= '0;
      attempt_limit  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        rbd_pkg::REG_START_WAIT:     start_wait     <= pwdata[DB-1:0];
        rbd_pkg::REG_WAIT_CAP:       wait_cap       <= pwdata[DB-1:0];
        rbd_pkg::REG_JITTER_PERCENT: jitter_percent <= pwdata[rbd_pkg::PCT_BITS-1:0];
        rbd_pkg::REG_ATTEMPT_LIMIT:  attempt_limit  <= pwdata[rbd_pkg::LIMIT_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rbd_pkg::REG_START_WAIT:     prdata = rbd_pkg::APB_DATA_BITS'(start_wait);
      rbd_pkg::REG_WAIT_CAP:       prdata = rbd_pkg::APB_DATA_BITS'(wait_cap);
      rbd_pkg::REG_JITTER_PERCENT: prdata = rbd_pkg::APB_DATA_BITS'(jitter_percent);
      rbd_pkg::REG_ATTEMPT_LIMIT:  prdata = rbd_pkg::APB_DATA_BITS'(attempt_limit);
    endcase
  end

  // pipeline
  stage_t stg [NS];
  stage_t nxt [NS];
  logic   vld [NS];
  logic   src_vld [NS];
  logic   rdy [NS+1];

  assign rdy[NS]   = rsp.ready;
  assign req.ready = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage

    assign rdy[k] = !vld[k] || rdy[k+1];

    if (k == 0) begin : g_entry
      assign src_vld[k] = req.valid;

      // backoff: base doubled (attempt-1) times, saturating to wait_cap
      always_comb begin
        logic [rbd_pkg::ATTEMPT_BITS-1:0] shift_amt;
        logic [2*DB-1:0]                  shifted;
        shift_amt = req.attempt_number - rbd_pkg::ATTEMPT_BITS'(2);
        shifted   = (2*DB)'(start_wait) << shift_amt[SW-1:0];
        nxt[k]         = '0;
        nxt[k].rnd     = req.random_word;
        nxt[k].allowed = (attempt_limit == '0) ||
                         (req.next_attempt_number <= attempt_limit);
        if (start_wait == '0) begin
          nxt[k].delay = '0;
        end else if (req.attempt_number <= rbd_pkg::ATTEMPT_BITS'(1)) begin
          nxt[k].delay = start_wait;
        end else if (start_wait >= wait_cap) begin
          nxt[k].delay = wait_cap;
        end else if (shift_amt >= rbd_pkg::ATTEMPT_BITS'(DB)) begin
          nxt[k].delay = wait_cap;
        end else if (shifted <= (2*DB)'(wait_cap >> 1)) begin
          nxt[k].delay = {shifted[DB-2:0], 1'b0};
        end else begin
          nxt[k].delay = wait_cap;
        end
      end
    end else begin : g_body
      assign src_vld[k] = vld[k-1];

      if (k == 1) begin : g_quo
        // delay / 100 by reciprocal multiplication
        always_comb begin
          logic [QW-1:0] prod;
          prod       = QW'(stg[k-1].delay) * QW'(rbd_pkg::PCT_RECIP);
          nxt[k]     = stg[k-1];
          nxt[k].quo = DB'(prod >> rbd_pkg::PCT_RECIP_SHIFT);
        end
      end else if (k == 2) begin : g_rem
        always_comb begin
          logic [DB-1:0] back;
          back        = stg[k-1].quo * DB'(rbd_pkg::PCT_DIVISOR);
          nxt[k]      = stg[k-1];
          nxt[k].prem = rbd_pkg::PCT_REM_BITS'(stg[k-1].delay - back);
          nxt[k].num  = PW'(stg[k-1].quo) * PW'(jitter_percent);
        end
      end else if (k == 3) begin : g_frac
        always_comb begin
          nxt[k]       = stg[k-1];
          nxt[k].tprod = rbd_pkg::FRAC_BITS'(stg[k-1].prem) *
                         rbd_pkg::FRAC_BITS'(jitter_percent);
        end
      end else if (k == 4) begin : g_jit
        // jitter = quotient * percent + (remainder * percent) / 100
        always_comb begin
          logic [FW-1:0] scaled;
          scaled     = FW'(stg[k-1].tprod) * FW'(rbd_pkg::FRAC_RECIP);
          nxt[k]     = stg[k-1];
          nxt[k].num = stg[k-1].num + PW'(scaled >> rbd_pkg::FRAC_RECIP_SHIFT);
        end
      end else if (k == PREP) begin : g_prep
        always_comb begin
          logic [DB-1:0] jitter;
          if (stg[k-1].num > PW'(stg[k-1].delay)) begin
            jitter = stg[k-1].delay;
          end else begin
            jitter = stg[k-1].num[DB-1:0];
          end
          nxt[k]       = stg[k-1];
          nxt[k].jz    = (jitter == '0);
          nxt[k].range = {jitter, 1'b1};
          nxt[k].lo    = stg[k-1].delay - jitter;
          nxt[k].mrem  = '0;
        end
      end else if (k < LAST) begin : g_mod
        // restoring modulo, one random bit per stage
        always_comb begin
          logic [DB+1:0] trial;
          trial  = {stg[k-1].mrem, stg[k-1].rnd[RB-1]};
          nxt[k] = stg[k-1];
          if (trial >= (DB+2)'(stg[k-1].range)) begin
            nxt[k].mrem = (DB+1)'(trial - (DB+2)'(stg[k-1].range));
          end else begin
            nxt[k].mrem = trial[DB:0];
          end
          nxt[k].rnd = {stg[k-1].rnd[RB-2:0], 1'b0};
        end
      end else begin : g_final
        always_comb begin
          logic [DB+1:0] sum;
          sum    = (DB+2)'(stg[k-1].lo) + (DB+2)'(stg[k-1].mrem);
          nxt[k] = stg[k-1];
          if (!stg[k-1].jz) begin
            if (sum > (DB+2)'(wait_cap)) begin
              nxt[k].delay = wait_cap;
            end else begin
              nxt[k].delay = sum[DB-1:0];
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld[k]) begin
        stg[k] <= nxt[k];
      end
    end
  end

  assign rsp.valid           = vld[NS-1];
  assign rsp.wait_ms         = stg[NS-1].delay;
  assign rsp.attempt_allowed = stg[NS-1].allowed;

endmodule
